@@ design/ghtc_pkg.sv @@
// ----------------------------------------------------------------------------
// ghtc_pkg
// shared widths, constants and codes of the gyro heading turn controller
// ----------------------------------------------------------------------------
package ghtc_pkg;

  // field widths
  localparam int SampleW  = 16;
  localparam int MsW      = 16;
  localparam int TargetW  = 21;
  localparam int SpeedW   = 8;
  localparam int AngleW   = 22;
  localparam int PhaseW   = 2;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 21;

  // internal widths
  localparam int CalCntW  = 8;
  localparam int CalSumW  = 24;
  localparam int OffsetW  = 25;
  localparam int DiffW    = 26;
  localparam int ProdW    = DiffW + MsW + 1;
  localparam int AccW     = 64;
  localparam int DivW     = 37;
  localparam int QuotW    = 25;
  localparam int RemW     = 16;
  localparam int MagW     = 21;
  localparam int MulCntW  = $clog2(MsW + 1);
  localparam int DivCntW  = $clog2(DivW + 1);

  // constants
  localparam logic [CalCntW-1:0]  CalSamples = 8'd200;
  localparam logic [RemW-1:0]     CalDiv     = RemW'(CalSamples);
  localparam logic [RemW-1:0]     AngleDiv   = 16'd41984;
  localparam logic [MagW-1:0]     AngleLim   = 21'd2000000;
  localparam logic [AccW-1:0]     LimMag     = 64'd83968041984;

  localparam logic [TargetW-1:0]  TargetRst  = 21'd9000;
  localparam logic [SpeedW-1:0]   SpeedRst   = 8'd150;

  // phase codes
  localparam logic [PhaseW-1:0]   PhaseCal   = 2'd0;
  localparam logic [PhaseW-1:0]   PhaseTurn  = 2'd1;
  localparam logic [PhaseW-1:0]   PhaseDone  = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0]  CfgTarget  = 1'b0;
  localparam logic [CfgIdxW-1:0]  CfgSpeed   = 1'b1;

endpackage

@@ design/ghtc_if.sv @@
// ----------------------------------------------------------------------------
// ghtc_in_if / ghtc_out_if
// valid/ready channels for gyro samples and controller results
// ----------------------------------------------------------------------------
interface ghtc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ghtc_pkg::SampleW-1:0] rate_sample;
  logic        [ghtc_pkg::MsW-1:0]     elapsed_ms;

  modport source (output valid, output rate_sample, output elapsed_ms, input ready);
  modport sink   (input valid, input rate_sample, input elapsed_ms, output ready);
endinterface

interface ghtc_out_if;
  logic                               valid;
  logic                               ready;
  logic        [ghtc_pkg::PhaseW-1:0] phase;
  logic        [ghtc_pkg::SpeedW-1:0] drive_pwm;
  logic signed [ghtc_pkg::AngleW-1:0] angle_centideg;
  logic                               turn_done;

  modport source (output valid, output phase, output drive_pwm, output angle_centideg,
                  output turn_done, input ready);
  modport sink   (input valid, input phase, input drive_pwm, input angle_centideg,
                  input turn_done, output ready);
endinterface

@@ design/gyro_heading_turn_controller_core.sv @@
// calibration sample: result goes through the output state; the last one first runs the divider for the offset
// turning sample: runs the 16-step serial multiplier, then accumulate, magnitude, limit check and the
// 37-step serial divider that turns the accumulator into centidegrees
// turning sample with a saturated angle skips the divider
// done-phase sample: goes straight to the output state; one sample in flight, a result waits in the output register
// reset clears phase, calibration, accumulator and restores the register defaults
// ----------------------------------------------------------------------------
// gyro_heading_turn_controller_core
// gyro bias calibration, rate integration and turn drive control
// ----------------------------------------------------------------------------
module gyro_heading_turn_controller_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ghtc_in_if.sink                          in_i,
  ghtc_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [ghtc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ghtc_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CDIV = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_MAG  = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_ADIV = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam int NumW = ghtc_pkg::CalSumW + 8;
  localparam int ExtW = ghtc_pkg::AccW + 1 - ghtc_pkg::ProdW;

  logic [2:0]                      state_q, state_d;
  logic [ghtc_pkg::PhaseW-1:0]     phase_q, phase_d;
  logic [ghtc_pkg::CalCntW-1:0]    cal_count_q, cal_count_d;
  logic [ghtc_pkg::CalSumW-1:0]    cal_sum_q, cal_sum_d;
  logic [ghtc_pkg::OffsetW-1:0]    offset_q, offset_d;
  logic [ghtc_pkg::AccW-1:0]       acc_q, acc_d;
  logic [ghtc_pkg::AccW-1:0]       mag_q, mag_d;
  logic                            neg_q, neg_d;
  logic [ghtc_pkg::AngleW-1:0]     angle_q, angle_d;
  logic [ghtc_pkg::TargetW-1:0]    target_q;
  logic [ghtc_pkg::SpeedW-1:0]     speed_q;

  logic [ghtc_pkg::PhaseW-1:0]     res_phase_q, res_phase_d;
  logic [ghtc_pkg::SpeedW-1:0]     res_pwm_q, res_pwm_d;
  logic [ghtc_pkg::AngleW-1:0]     res_angle_q, res_angle_d;
  logic                            res_done_q, res_done_d;

  logic                            out_valid_q;
  logic [ghtc_pkg::PhaseW-1:0]     out_phase_q;
  logic [ghtc_pkg::SpeedW-1:0]     out_pwm_q;
  logic [ghtc_pkg::AngleW-1:0]     out_angle_q;
  logic                            out_done_q;
  logic                            out_load;

  logic                            in_acc;
  logic [ghtc_pkg::CalCntW-1:0]    cal_count_nx;
  logic [ghtc_pkg::CalSumW-1:0]    cal_sum_nx;
  logic                            cal_last;
  logic [NumW-1:0]                 cal_num;
  logic [NumW-1:0]                 cal_mag;
  logic [ghtc_pkg::DiffW-1:0]      diff;
  logic [ghtc_pkg::AccW:0]         acc_sum;
  logic [ghtc_pkg::OffsetW-1:0]    quot_neg;

  logic                            mul_start;
  logic                            mul_done;
  logic [ghtc_pkg::ProdW-1:0]      mul_prod;
  logic                            div_start;
  logic                            div_done;
  logic [ghtc_pkg::DivW-1:0]       div_dividend;
  logic [ghtc_pkg::RemW-1:0]       div_divisor;
  logic [ghtc_pkg::QuotW-1:0]      div_quot;

  logic                            fin_en;
  logic [ghtc_pkg::MagW-1:0]       fin_mag;
  logic [ghtc_pkg::AngleW-1:0]     fin_ang;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && (state_q == S_IDLE);

  assign cal_count_nx = cal_count_q + 1'b1;
  assign cal_sum_nx   = cal_sum_q + {{(ghtc_pkg::CalSumW-ghtc_pkg::SampleW){in_i.rate_sample[ghtc_pkg::SampleW-1]}},
                                     in_i.rate_sample};
  assign cal_last     = (cal_count_nx >= ghtc_pkg::CalSamples) || (cal_count_nx == '0);
  assign cal_num      = {cal_sum_nx, 8'b0};
  assign cal_mag      = cal_sum_nx[ghtc_pkg::CalSumW-1] ? (~cal_num + 1'b1) : cal_num;

  assign diff = {{2{in_i.rate_sample[ghtc_pkg::SampleW-1]}}, in_i.rate_sample, 8'b0}
              - {offset_q[ghtc_pkg::OffsetW-1], offset_q};

  assign acc_sum = {acc_q[ghtc_pkg::AccW-1], acc_q}
                 + {{ExtW{mul_prod[ghtc_pkg::ProdW-1]}}, mul_prod};

  assign quot_neg = ~div_quot + 1'b1;
  assign fin_ang  = neg_q ? (~{1'b0, fin_mag} + 1'b1) : {1'b0, fin_mag};

  ghtc_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (diff),
    .mplier_i (in_i.elapsed_ms),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  ghtc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    cal_count_d  = cal_count_q;
    cal_sum_d    = cal_sum_q;
    offset_d     = offset_q;
    acc_d        = acc_q;
    mag_d        = mag_q;
    neg_d        = neg_q;
    angle_d      = angle_q;
    res_phase_d  = res_phase_q;
    res_pwm_d    = res_pwm_q;
    res_angle_d  = res_angle_q;
    res_done_d   = res_done_q;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    div_dividend = mag_q[ghtc_pkg::DivW-1:0];
    div_divisor  = ghtc_pkg::AngleDiv;
    fin_en       = 1'b0;
    fin_mag      = '0;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (phase_q == ghtc_pkg::PhaseCal) begin
            cal_sum_d   = cal_sum_nx;
            cal_count_d = cal_count_nx;
            res_phase_d = ghtc_pkg::PhaseCal;
            res_pwm_d   = '0;
            res_angle_d = '0;
            res_done_d  = 1'b0;
            if (cal_last) begin
              div_start    = 1'b1;
              div_dividend = {{(ghtc_pkg::DivW-NumW){1'b0}}, cal_mag};
              div_divisor  = ghtc_pkg::CalDiv;
              neg_d        = cal_sum_nx[ghtc_pkg::CalSumW-1];
              state_d      = S_CDIV;
            end else begin
              state_d = S_OUT;
            end
          end else if (phase_q == ghtc_pkg::PhaseTurn) begin
            mul_start = 1'b1;
            state_d   = S_MUL;
          end else begin
            // done phase holds the last angle
            res_phase_d = ghtc_pkg::PhaseDone;
            res_pwm_d   = '0;
            res_angle_d = angle_q;
            res_done_d  = 1'b1;
            state_d     = S_OUT;
          end
        end
      end
      S_CDIV: begin
        if (div_done) begin
          offset_d = neg_q ? quot_neg : div_quot;
          phase_d  = ghtc_pkg::PhaseTurn;
          state_d  = S_OUT;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        // saturating accumulate
        if (acc_sum[ghtc_pkg::AccW] != acc_sum[ghtc_pkg::AccW-1]) begin
          acc_d = acc_sum[ghtc_pkg::AccW] ? {1'b1, {(ghtc_pkg::AccW-1){1'b0}}}
                                          : {1'b0, {(ghtc_pkg::AccW-1){1'b1}}};
        end else begin
          acc_d = acc_sum[ghtc_pkg::AccW-1:0];
        end
        state_d = S_MAG;
      end
      S_MAG: begin
        neg_d   = acc_q[ghtc_pkg::AccW-1];
        mag_d   = acc_q[ghtc_pkg::AccW-1] ? (~acc_q + 1'b1) : acc_q;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (mag_q >= ghtc_pkg::LimMag) begin
          fin_en  = 1'b1;
          fin_mag = ghtc_pkg::AngleLim;
        end else begin
          div_start = 1'b1;
          state_d   = S_ADIV;
        end
      end
      S_ADIV: begin
        if (div_done) begin
          fin_en  = 1'b1;
          fin_mag = div_quot[ghtc_pkg::MagW-1:0];
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // target compare after integration
    if (fin_en) begin
      angle_d     = fin_ang;
      res_angle_d = fin_ang;
      if (fin_mag < target_q) begin
        res_phase_d = ghtc_pkg::PhaseTurn;
        res_pwm_d   = speed_q;
        res_done_d  = 1'b0;
      end else begin
        phase_d     = ghtc_pkg::PhaseDone;
        res_phase_d = ghtc_pkg::PhaseDone;
        res_pwm_d   = '0;
        res_done_d  = 1'b1;
      end
      state_d = S_OUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= ghtc_pkg::PhaseCal;
      cal_count_q <= '0;
      cal_sum_q   <= '0;
      offset_q    <= '0;
      acc_q       <= '0;
      angle_q     <= '0;
      target_q    <= ghtc_pkg::TargetRst;
      speed_q     <= ghtc_pkg::SpeedRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cal_count_q <= cal_count_d;
      cal_sum_q   <= cal_sum_d;
      offset_q    <= offset_d;
      acc_q       <= acc_d;
      angle_q     <= angle_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ghtc_pkg::CfgTarget: target_q <= cfg_wdata_i[ghtc_pkg::TargetW-1:0];
          ghtc_pkg::CfgSpeed:  speed_q  <= cfg_wdata_i[ghtc_pkg::SpeedW-1:0];
          default:             target_q <= target_q;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    neg_q       <= neg_d;
    res_phase_q <= res_phase_d;
    res_pwm_q   <= res_pwm_d;
    res_angle_q <= res_angle_d;
    res_done_q  <= res_done_d;
    if (out_load) begin
      out_phase_q <= res_phase_q;
      out_pwm_q   <= res_pwm_q;
      out_angle_q <= res_angle_q;
      out_done_q  <= res_done_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.phase          = out_phase_q;
  assign out_o.drive_pwm      = out_pwm_q;
  assign out_o.angle_centideg = out_angle_q;
  assign out_o.turn_done      = out_done_q;

endmodule

@@ design/ghtc_mul.sv @@
// ----------------------------------------------------------------------------
// ghtc_mul
// bit-serial signed by unsigned shift-add multiplier, one multiplier bit a cycle
// ----------------------------------------------------------------------------
module ghtc_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ghtc_pkg::DiffW-1:0] mcand_i,
  input  logic        [ghtc_pkg::MsW-1:0]   mplier_i,
  output logic                              done_o,
  output logic signed [ghtc_pkg::ProdW-1:0] prod_o
);

  localparam int HiW = ghtc_pkg::DiffW + 1;

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [ghtc_pkg::MulCntW-1:0]    cnt_q, cnt_d;
  logic [HiW-1:0]                  hi_q, hi_d;
  logic [ghtc_pkg::MsW-1:0]        lo_q, lo_d;
  logic [ghtc_pkg::DiffW-1:0]      mcand_q, mcand_d;
  logic [HiW:0]                    sum;

  always_comb begin
    sum = {hi_q[HiW-1], hi_q}
        + (lo_q[0] ? {{2{mcand_q[ghtc_pkg::DiffW-1]}}, mcand_q} : '0);
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    mcand_d = mcand_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = ghtc_pkg::MulCntW'(ghtc_pkg::MsW);
      hi_d    = '0;
      lo_d    = mplier_i;
      mcand_d = mcand_i;
    end else if (busy_q) begin
      hi_d  = sum[HiW:1];
      lo_d  = {sum[0], lo_q[ghtc_pkg::MsW-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ghtc_pkg::MulCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    mcand_q <= mcand_d;
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

@@ design/ghtc_div.sv @@
// ----------------------------------------------------------------------------
// ghtc_div
// restoring bit-serial divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module ghtc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ghtc_pkg::DivW-1:0]      dividend_i,
  input  logic [ghtc_pkg::RemW-1:0]      divisor_i,
  output logic                           done_o,
  output logic [ghtc_pkg::QuotW-1:0]     quot_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [ghtc_pkg::DivCntW-1:0]    cnt_q, cnt_d;
  logic [ghtc_pkg::RemW-1:0]       rem_q, rem_d;
  logic [ghtc_pkg::DivW-1:0]       quo_q, quo_d;
  logic [ghtc_pkg::RemW-1:0]       dvs_q, dvs_d;
  logic [ghtc_pkg::RemW:0]         trial;
  logic [ghtc_pkg::RemW:0]         delta;
  logic                            ge;

  always_comb begin
    trial   = {rem_q, quo_q[ghtc_pkg::DivW-1]};
    delta   = trial - {1'b0, dvs_q};
    ge      = (trial >= {1'b0, dvs_q});
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = ghtc_pkg::DivCntW'(ghtc_pkg::DivW);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? delta[ghtc_pkg::RemW-1:0] : trial[ghtc_pkg::RemW-1:0];
      quo_d = {quo_q[ghtc_pkg::DivW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ghtc_pkg::DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q[ghtc_pkg::QuotW-1:0];

endmodule
